// ===== rtl/difficulty_to_target_words_unit_defines.svh =====
// assertion macros shared by the checker
// no dependencies
`ifndef DIFFICULTY_TO_TARGET_WORDS_UNIT_DEFINES_SVH
`define DIFFICULTY_TO_TARGET_WORDS_UNIT_DEFINES_SVH
`define DTW_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define DTW_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`endif

// ===== rtl/dtw_pkg.sv =====
// shared types and constants for the difficulty to target converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package dtw_pkg;
  localparam logic [52:0] NUMER_MANT = 53'h1FFFE000000000; // 4294901760 as a 53-bit significand
  localparam int NUMER_EXP = 31;               // unbiased exponent of 4294901760
  localparam logic [2:0] START_POS = 3'd6;
  localparam logic [2:0] LAST_IDX = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/difficulty_to_target_words_unit.sv =====
// difficulty_to_target_words_unit: double difficulty in, eight 32-bit target words out
// depends on dtw_pkg
//
// usage:
//   in_tdata carries the 64-bit raw double difficulty; in_tready is high only when the
//   block is idle, so one request is worked at a time.
//   out_tdata = {invalid, word_value, word_index} packed low first; out_tlast marks word 7.
//   the words follow in index order, 0 first.
//   sequence: the request is classified as it is accepted, then restoring division
//   (one quotient bit a cycle through a shifting remainder), a rounding state, then
//   eight words, one a cycle while the receiver keeps out_tready high.
//   the divider loop does one subtract per quotient bit.
//   scaling by 2^-32 is an exponent subtract, so the word position is found at once.
//   a stall on the output holds the current word; nothing is lost.
//   reset (rst_n low, synchronous) returns to idle and drops any request in flight.
`timescale 1ns / 1ps
`default_nettype none
module difficulty_to_target_words_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // difficulty_bits[63:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // word_index[2:0], word_value[34:3], invalid[35], zero pad
  output logic        out_tlast
);
  localparam int DIV_STEPS = 67; // 64 integer bits plus guard and round, one sticky below

  dtw_pkg::state_t state_r, state_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [54:0] rem_r, rem_nxt;       // partial remainder
  logic [52:0] den_r, den_nxt;       // divisor mantissa
  logic [66:0] quo_r, quo_nxt;       // quotient bits shifted in lsb first
  logic [7:0]  sh_r, sh_nxt;         // quotient weight: value = quo * 2^(sh-66) style shift
  logic [2:0]  pos_r, pos_nxt;
  logic        bad_r, bad_nxt;
  logic        zero_r, zero_nxt;
  logic [63:0] cmp_r, cmp_nxt;
  logic [2:0]  idx_r, idx_nxt;

  // decode the input double
  logic        s_in;
  logic [10:0] e_in;
  logic [51:0] f_in;
  logic        nan_in, inf_in, zro_in, sub_in;
  logic [52:0] m_in;
  logic signed [12:0] ue;            // unbiased exponent of d
  logic signed [12:0] ue_sc;         // after scaling
  logic [2:0]  ndiv;
  logic        gt1;
  logic [54:0] diff;
  logic signed [12:0] qexp;

  assign s_in   = in_tdata[63];
  assign e_in   = in_tdata[62:52];
  assign f_in   = in_tdata[51:0];
  assign nan_in = (e_in == 11'h7FF) && (f_in != 52'd0);
  assign inf_in = (e_in == 11'h7FF) && (f_in == 52'd0);
  assign zro_in = (e_in == 11'd0) && (f_in == 52'd0);
  assign sub_in = (e_in == 11'd0);
  assign m_in   = {!sub_in, f_in};
  assign ue     = sub_in ? -13'sd1022 : ($signed({2'b00, e_in}) - 13'sd1023);
  assign gt1    = (ue > 0) || ((ue == 0) && (f_in != 52'd0));

  // number of /2^32 steps: while d>1 divide, at most six times (exact, no rounding)
  always_comb begin
    ndiv = 3'd0;
    if (gt1) begin
      // d > 2^(32k) with equality counting only when fraction nonzero
      for (int k = 1; k < 6; k++) begin
        if ((ue > 13'(32 * k)) || ((ue == 13'(32 * k)) && (f_in != 52'd0)))
          ndiv = 3'(k + 1);
      end
      if (ndiv == 3'd0) ndiv = 3'd1;
    end
  end
  assign ue_sc = ue - $signed({5'd0, ndiv, 5'd0});

  assign diff = rem_r - {2'b00, den_r};

  // quo holds 67 bits; msb weight 2^sh (first step compares num>=den, ratio in [0.5,2))
  // so bit i (from lsb) has weight 2^(sh-66+i). round the 53 significant bits to nearest
  // even, then truncate to integer.
  function automatic logic [64:0] round_full(input logic [66:0] q, input logic st,
                                             input logic [7:0] sh);
    logic [66:0] qn;
    logic [6:0]  lsbpos;
    logic [66:0] one, half, mask, low;
    logic [67:0] r;
    logic        lead;
    logic [7:0]  s;
    begin
      lead = q[66];
      // significand is 53 bits below the leading one
      lsbpos = lead ? 7'd14 : 7'd13;
      one  = 67'd1 << lsbpos;
      half = one >> 1;
      mask = one - 67'd1;
      low  = q & mask;
      qn   = q & ~mask;
      r    = {1'b0, qn};
      if (low > half || (low == half && (st || q[lsbpos])) )
        r = r + {1'b0, one};
      // shift to integer: weight of bit i is 2^(sh-66+i)
      s = sh;
      if (s >= 8'd66) round_full = 65'(r << (s - 8'd66));
      else round_full = 65'(r >> (8'd66 - s));
    end
  endfunction

  function automatic logic [63:0] round_trunc(input logic [66:0] q, input logic st,
                                              input logic [7:0] sh);
    logic [64:0] v;
    begin
      v = round_full(q, st, sh);
      round_trunc = v[63:0];
    end
  endfunction

  // quotient of 2^64 or more after rounding
  function automatic logic ovf_chk(input logic [66:0] q, input logic st,
                                   input logic [7:0] sh);
    logic [64:0] v;
    begin
      v = round_full(q, st, sh);
      ovf_chk = v[64];
    end
  endfunction

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    quo_nxt   = quo_r;
    sh_nxt    = sh_r;
    pos_nxt   = pos_r;
    bad_nxt   = bad_r;
    zero_nxt  = zero_r;
    cmp_nxt   = cmp_r;
    idx_nxt   = idx_r;
    qexp      = '0;
    case (state_r)
      dtw_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          pos_nxt  = dtw_pkg::START_POS - ndiv;
          bad_nxt  = 1'b0;
          zero_nxt = 1'b0;
          idx_nxt  = '0;
          cnt_nxt  = '0;
          quo_nxt  = '0;
          // normalize subnormal mantissa is not needed: tiny values overflow anyway
          den_nxt  = m_in;
          rem_nxt  = {2'b00, dtw_pkg::NUMER_MANT};
          // quotient exponent: 31 - ue_sc; result bit weight from msb of 67-bit quotient
          qexp     = 13'(dtw_pkg::NUMER_EXP) - ue_sc;
          sh_nxt   = qexp[7:0];
          if (nan_in || s_in || zro_in) begin
            bad_nxt   = 1'b1;
            state_nxt = dtw_pkg::ST_FIN;
          end else if (inf_in) begin
            zero_nxt  = 1'b1;
            state_nxt = dtw_pkg::ST_FIN;
          end else if (ndiv == 3'd0 && (qexp > 13'sd64 || sub_in)) begin
            // exponent 64 can still land below 2^64 when the mantissa ratio is under one
            bad_nxt   = 1'b1;
            state_nxt = dtw_pkg::ST_FIN;
          end else if (qexp < 13'sd0) begin
            zero_nxt  = 1'b1;
            state_nxt = dtw_pkg::ST_FIN;
          end else begin
            state_nxt = dtw_pkg::ST_DIV;
          end
        end
      end
      dtw_pkg::ST_DIV: begin
        // restoring step; quotient bit 0 of weight 2^(sh) at first step... ratio in [0.5,2)
        if (!diff[54]) begin
          rem_nxt = {diff[53:0], 1'b0};
          quo_nxt = {quo_r[65:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[53:0], 1'b0};
          quo_nxt = {quo_r[65:0], 1'b0};
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(DIV_STEPS - 1)) state_nxt = dtw_pkg::ST_FIN;
      end
      dtw_pkg::ST_FIN: begin
        state_nxt = dtw_pkg::ST_EMIT;
        if (!bad_r && !zero_r) begin
          cmp_nxt = round_trunc(quo_r, rem_r != 55'd0, sh_r);
          // quotient 2^64 after rounding: only possible at position 6 by bad check
          if (ovf_chk(quo_r, rem_r != 55'd0, sh_r)) begin
            if (pos_r == dtw_pkg::START_POS) bad_nxt = 1'b1;
            else cmp_nxt = '0;
          end
        end else begin
          cmp_nxt = '0;
        end
      end
      dtw_pkg::ST_EMIT: begin
        if (out_tready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == dtw_pkg::LAST_IDX) state_nxt = dtw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dtw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtw_pkg::ST_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      bad_r   <= 1'b0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      bad_r   <= bad_nxt;
      zero_r  <= zero_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
    sh_r  <= sh_nxt;
    pos_r <= pos_nxt;
    cmp_r <= cmp_nxt;
  end

  logic [31:0] wval;
  always_comb begin
    if (bad_r) wval = 32'hFFFF_FFFF;
    else if (idx_r == pos_r) wval = cmp_r[31:0];
    else if (idx_r == pos_r + 3'd1) wval = cmp_r[63:32];
    else wval = '0;
  end

  assign in_tready  = (state_r == dtw_pkg::ST_IDLE);
  assign out_tvalid = (state_r == dtw_pkg::ST_EMIT);
  assign out_tdata  = {4'd0, bad_r, wval, idx_r};
  assign out_tlast  = (idx_r == dtw_pkg::LAST_IDX);
endmodule
`default_nettype wire

// ===== rtl/dtw_checker.sv =====
// port-level checks for difficulty_to_target_words_unit
// depends on difficulty_to_target_words_unit_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "difficulty_to_target_words_unit_defines.svh"
module dtw_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [39:0] out_tdata,
  input wire        out_tlast
);
  `DTW_ASSERT(a_no_overlap, clk, rst_n, !(in_tready && out_tvalid))
  `DTW_ASSERT(a_last_idx, clk, rst_n, out_tvalid |-> (out_tlast == (out_tdata[2:0] == 3'd7)))
  `DTW_ASSERT(a_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
  `DTW_ASSERT(a_busy, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready)
  `DTW_ASSERT_NR(a_rst, clk, !rst_n |=> (in_tready && !out_tvalid))
endmodule
bind difficulty_to_target_words_unit dtw_checker u_dtw_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
`default_nettype wire

// ===== verif/tb_top.sv =====
// testbench for difficulty_to_target_words_unit: directed and random difficulties,
// predicted per request with native double arithmetic; depends on the rtl and dtw_pkg
`timescale 1ns / 1ps
module tb_top;
  typedef struct packed {
    logic [2:0]  idx;
    logic [31:0] value;
    logic        last;
    logic        invalid;
  } target_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;

  target_word_t target_q[$];
  int errors;
  int requests;
  int bad_requests;
  int words_seen;
  int cycles;
  bit tx_quiet;
  bit rx_quiet;
  bit hold_go;
  int hold_len;
  int hold_left;
  int stall_left;

  localparam int LIMIT = 400000;

  difficulty_to_target_words_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  // truncate a double in [0, 2^64) toward zero
  function automatic logic [63:0] trunc_u64(real q);
    logic [63:0] b;
    logic [63:0] m;
    int e;
    b = $realtobits(q);
    e = int'(b[62:52]) - 1075;
    m = {11'd0, 1'b1, b[51:0]};
    if (int'(b[62:52]) < 1023) return 64'd0;
    if (e >= 0) return m << e;
    return m >> (-e);
  endfunction

  task automatic predict_target(input logic [63:0] raw);
    real d;
    real q;
    int pos;
    bit bad;
    logic [63:0] compact;
    logic [31:0] w[8];
    target_word_t t;
    d = $bitstoreal(raw);
    pos = int'(dtw_pkg::START_POS);
    bad = 0;
    compact = 64'd0;
    while (pos > 0 && d > 1.0) begin
      d = d / 4294967296.0;
      pos--;
    end
    if (pos == int'(dtw_pkg::START_POS)) begin
      if (!(d > 0.0)) bad = 1;
      else begin
        q = 4294901760.0 / d;
        if (!(q < 18446744073709551616.0)) bad = 1;
        else compact = trunc_u64(q);
      end
    end else begin
      q = 4294901760.0 / d;
      if (q >= 0.0 && q < 18446744073709551616.0) compact = trunc_u64(q);
    end
    for (int k = 0; k < 8; k++) w[k] = bad ? 32'hFFFF_FFFF : 32'd0;
    if (!bad) begin
      w[pos & 7] = compact[31:0];
      w[(pos + 1) & 7] = compact[63:32];
    end
    requests++;
    if (bad) bad_requests++;
    for (int k = 0; k < 8; k++) begin
      t.idx = k[2:0];
      t.value = w[k];
      t.last = (k[2:0] == dtw_pkg::LAST_IDX);
      t.invalid = bad;
      target_q.push_back(t);
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // word checker
  always @(posedge clk) begin
    target_word_t t;
    if (rst_n && out_tvalid && out_tready) begin
      words_seen++;
      if (target_q.size() == 0) report("unexpected word", 64'(out_tdata), 64'd0);
      else begin
        t = target_q.pop_front();
        if (out_tdata[2:0] !== t.idx)
          report("word_index", 64'(out_tdata[2:0]), 64'(t.idx));
        if (out_tdata[34:3] !== t.value)
          report("word_value", 64'(out_tdata[34:3]), 64'(t.value));
        if (out_tdata[35] !== t.invalid)
          report("invalid", 64'(out_tdata[35]), 64'(t.invalid));
        if (out_tdata[39:36] !== 4'd0) report("pad", 64'(out_tdata[39:36]), 64'd0);
        if (out_tlast !== t.last) report("last_word", 64'(out_tlast), 64'(t.last));
      end
    end
  end

  // receiver stalls: random short bursts, or one long hold on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 0;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_difficulty(input logic [63:0] raw);
    in_tvalid <= 1'b1;
    in_tdata <= raw;
    do @(posedge clk); while (!in_tready);
    predict_target(raw);
    if (!tx_quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (target_q.size() != 0) @(posedge clk);
  endtask

  // plausible mining difficulty or raw noise
  function automatic logic [63:0] rand_difficulty;
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return r;
      1: return {1'b0, 11'($urandom_range(1023 - 40, 1023 + 200)), r[51:0]};
      2: return {1'b0, 11'($urandom_range(1023 - 34, 1023 - 30)), r[51:0]};
      default: return {1'b0, 11'($urandom_range(0, 2047)), r[51:0]};
    endcase
  endfunction

  task automatic test_directed;
    logic [63:0] vals[$];
    vals = {64'h0000000000000000, 64'h8000000000000000, 64'h7FF0000000000000,
            64'hFFF0000000000000, 64'h7FF8000000000000, 64'hFFF8000000000001,
            64'h3FF0000000000000, 64'h3FF0000000000001, 64'h3FE0000000000000,
            64'h3DF0000000000000, 64'h3DEFFFFFFFFFFFFF, 64'h3DF0000000000001,
            64'h0000000000000001, 64'h0010000000000000, 64'h41F0000000000000,
            64'h41F0000000000001, 64'h7FEFFFFFFFFFFFFF, 64'hBFF0000000000000,
            64'h408F400000000000, 64'h4530000000000000, 64'h4BF0000000000000,
            64'h4C00000000000000, 64'h4E00000000000000, 64'h3F50624DD2F1A9FC,
            64'hFFFFFFFFFFFFFFFF};
    foreach (vals[i]) send_difficulty(vals[i]);
  endtask

  task automatic test_random(input int n);
    repeat (n) send_difficulty(rand_difficulty());
  endtask

  // long receiver hold while requests keep coming, so the input stalls
  task automatic test_backpressure;
    hold_len = 400;
    hold_go = 1;
    repeat (4) send_difficulty(rand_difficulty());
  endtask

  task automatic test_pause;
    drain();
    repeat (3) send_difficulty(rand_difficulty());
    drain();
  endtask

  initial begin
    clk = 0;
    errors = 0;
    requests = 0;
    bad_requests = 0;
    words_seen = 0;
    cycles = 0;
    tx_quiet = 0;
    rx_quiet = 0;
    hold_go = 0;
    hold_len = 0;
    hold_left = 0;
    stall_left = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 64'd0;
    out_tready <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(110);
    test_backpressure();
    test_pause();
    test_random(100);
    tx_quiet = 1;
    rx_quiet = 1;
    test_random(40);

    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d difficulties (%0d forced to all-ones), %0d target words checked",
             requests, bad_requests, words_seen);
    $display("including signed zeros, infinities, nans, denormals and 2^-32 boundaries");
    if (errors == 0 && target_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
